>>> sv/sqb_pkg.sv
// ----------------------------------------------------------------------------
// sqb_pkg
// Shared types and constants of the sprite quad batcher.
// ----------------------------------------------------------------------------
package sqb_pkg;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam int          SLOT_W  = 4;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_PUSH   = 3'd1,
        OP_POP    = 3'd2,
        OP_SPRITE = 3'd3,
        OP_FLUSH  = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_BIND   = 2'd1,
        KIND_DRAW   = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
        logic               replace_top;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] size_w;
        logic signed [31:0] size_h;
        logic [15:0]        texture_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic signed [31:0] vert_w;
        logic [1:0]         corner;
        logic [3:0]         slot_number;
        logic [15:0]        bound_texture;
        logic [14:0]        draw_index_count;
        logic               last;
    } res_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] step;
    } tag_t;

endpackage

>>> sv/sqb_stack_mem.sv
// ----------------------------------------------------------------------------
// sqb_stack_mem
// Transform stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sqb_stack_mem #(
    parameter int DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [31:0]                wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [31:0]                rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/sqb_mac.sv
// ----------------------------------------------------------------------------
// sqb_mac
// Shared Q16.16 multiply-accumulate: registered product, then wrapping sum.
// ----------------------------------------------------------------------------
module sqb_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic               first,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic [31:0]        sum
);

    logic signed [63:0] prod_reg;
    logic               valid_reg;
    logic               first_reg;
    logic [31:0]        acc_reg;

    assign sum = (first_reg ? 32'd0 : acc_reg) + prod_reg[47:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
            first_reg <= first;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
            if (valid_reg)
            begin
                acc_reg <= sum;
            end
        end
    end

endmodule

>>> sv/sprite_quad_batcher_unit.sv
// ----------------------------------------------------------------------------
// sprite_quad_batcher_unit
// Sprite batcher with matrix stack, texture slot table and index counter.
// Sprite: 64 products through one shared multiply-add, with fill and drain,
//   after a slot table search that adds a missing id, and after a flush first
//   when a full table must take a new id. Multiplying push: 64 products too.
// Replacing push: staged copy. Flush: bindings, then draw. Dropped push: error.
// Result stalls hold the pipeline. Reset clears level, staged matrix, slot
//   and index counts; level zero reads as identity. No clearing pass after reset.
// ----------------------------------------------------------------------------
module sprite_quad_batcher_unit #(
    parameter int STACK_DEPTH = 16,
    parameter int SLOT_COUNT  = 15,
    parameter int MAX_QUADS   = 4096
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  sqb_pkg::cmd_t  cmd,
    output logic           res_valid,
    input  logic           res_stall,
    output sqb_pkg::res_t  res
);

    localparam int LW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int MD   = STACK_DEPTH * 16;
    localparam int SIW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CAPI = (MAX_QUADS * 6 > 32766) ? 32766 : MAX_QUADS * 6;
    localparam logic [14:0] CAP = 15'(CAPI);
    localparam logic [LW-1:0] TOP_LVL = LW'(STACK_DEPTH - 1);
    localparam logic [sqb_pkg::SLOT_W-1:0] SLOTS = sqb_pkg::SLOT_W'(SLOT_COUNT);

    typedef enum logic [2:0] {
        S_IDLE, S_ERR, S_COPY, S_SEARCH, S_FLUSH, S_DRAW, S_ISSUE, S_DRAIN
    } state_t;

    state_t                      state_reg, state_next;
    logic [LW-1:0]               level_reg, level_next;
    logic [31:0]                 staged_reg [16];
    logic [31:0]                 staged_next [16];
    logic [15:0]                 table_reg [SLOT_COUNT];
    logic [15:0]                 table_next [SLOT_COUNT];
    logic [sqb_pkg::SLOT_W-1:0]  count_reg, count_next;
    logic [sqb_pkg::SLOT_W-1:0]  idx_reg, idx_next;
    logic [sqb_pkg::SLOT_W-1:0]  slot_reg, slot_next;
    logic [14:0]                 quad_reg, quad_next;
    logic [5:0]                  step_reg, step_next;
    logic                        sprite_reg, sprite_next;
    logic                        ret_reg, ret_next;
    logic [31:0]                 px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic [31:0]                 cx_reg, cx_next, cy_reg, cy_next;
    logic [15:0]                 tid_reg, tid_next;
    logic [31:0]                 row_reg [3];
    logic [31:0]                 row_next [3];
    sqb_pkg::tag_t               t1_reg, t1_next, t2_reg, t2_next;
    logic                        res_valid_reg, res_valid_next;
    sqb_pkg::res_t               res_reg, res_next;

    logic                        adv;
    logic                        mem_we;
    logic [LW+3:0]               mem_waddr;
    logic [31:0]                 mem_wdata;
    logic [31:0]                 mem_rdata;
    logic [LW+3:0]               mem_raddr;
    logic [3:0]                  a_idx;
    logic [31:0]                 op_a, op_b;
    logic [31:0]                 mac_sum;
    logic [15:0]                 quad_sum;

    assign adv       = !(res_valid_reg && res_stall);
    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign quad_sum  = {1'b0, quad_reg} + 16'd6;

    assign a_idx     = sprite_reg ? t1_reg.step[3:0] : {t1_reg.step[5:4], t1_reg.step[1:0]};
    assign mem_raddr = {level_reg, (sprite_reg ? step_reg[3:0] : {step_reg[5:4], step_reg[1:0]})};

    always_comb
    begin
        if (level_reg == '0)
        begin
            op_a = (a_idx[3:2] == a_idx[1:0]) ? sqb_pkg::ONE_Q16 : 32'd0;
        end
        else
        begin
            op_a = mem_rdata;
        end
        if (sprite_reg)
        begin
            case (t1_reg.step[1:0])
                2'd0:    op_b = t1_reg.step[5] ? cx_reg : px_reg;
                2'd1:    op_b = (t1_reg.step[5:4] == 2'd1 || t1_reg.step[5:4] == 2'd2)
                                ? cy_reg : py_reg;
                2'd2:    op_b = pz_reg;
                default: op_b = sqb_pkg::ONE_Q16;
            endcase
        end
        else
        begin
            op_b = staged_reg[{t1_reg.step[1:0], t1_reg.step[3:2]}];
        end
    end

    sqb_stack_mem #(
        .DEPTH (MD)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr[$clog2(MD)-1:0]),
        .wdata (mem_wdata),
        .re    (adv),
        .raddr (mem_raddr[$clog2(MD)-1:0]),
        .rdata (mem_rdata)
    );

    sqb_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (t1_reg.valid),
        .first    (t1_reg.step[1:0] == 2'd0),
        .a        (op_a),
        .b        (op_b),
        .sum      (mac_sum)
    );

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        staged_next    = staged_reg;
        table_next     = table_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        quad_next      = quad_reg;
        step_next      = step_reg;
        sprite_next    = sprite_reg;
        ret_next       = ret_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pz_next        = pz_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        tid_next       = tid_reg;
        row_next       = row_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        mem_we         = 1'b0;
        mem_waddr      = {LW'(level_reg + 1'b1), step_reg[3:0]};
        mem_wdata      = staged_reg[step_reg[3:0]];

        if (adv)
        begin
            t1_next.valid = 1'b0;
            t1_next.step  = step_reg;
            t2_next       = t1_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    step_next = '0;
                    case (cmd.opcode)
                        sqb_pkg::OP_LOAD:
                        begin
                            staged_next[cmd.elem_index] = cmd.elem_value;
                        end
                        sqb_pkg::OP_PUSH:
                        begin
                            sprite_next = 1'b0;
                            if (level_reg == TOP_LVL)
                            begin
                                state_next = S_ERR;
                            end
                            else if (cmd.replace_top)
                            begin
                                state_next = S_COPY;
                            end
                            else
                            begin
                                state_next = S_ISSUE;
                            end
                        end
                        sqb_pkg::OP_POP:
                        begin
                            if (level_reg != '0)
                            begin
                                level_next = level_reg - 1'b1;
                            end
                        end
                        sqb_pkg::OP_SPRITE:
                        begin
                            sprite_next = 1'b1;
                            px_next     = cmd.pos_x;
                            py_next     = cmd.pos_y;
                            pz_next     = cmd.pos_z;
                            cx_next     = cmd.pos_x + cmd.size_w;
                            cy_next     = cmd.pos_y + cmd.size_h;
                            tid_next    = cmd.texture_id;
                            idx_next    = '0;
                            slot_next   = '0;
                            state_next  = (cmd.texture_id == '0) ? S_ISSUE : S_SEARCH;
                        end
                        sqb_pkg::OP_FLUSH:
                        begin
                            idx_next   = '0;
                            ret_next   = 1'b0;
                            state_next = S_FLUSH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ERR:
            begin
                if (adv)
                begin
                    res_next       = '0;
                    res_next.kind  = sqb_pkg::KIND_ERROR;
                    res_next.last  = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_COPY:
            begin
                mem_we    = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg[3:0] == 4'd15)
                begin
                    level_next = level_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (idx_reg == count_reg)
                begin
                    if (count_reg == SLOTS)
                    begin
                        idx_next   = '0;
                        ret_next   = 1'b1;
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        table_next[count_reg[SIW-1:0]] = tid_reg;
                        count_next = count_reg + 1'b1;
                        slot_next  = count_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
                else if (table_reg[idx_reg[SIW-1:0]] == tid_reg)
                begin
                    slot_next  = idx_reg + 1'b1;
                    state_next = S_ISSUE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = S_DRAW;
                end
                else if (adv)
                begin
                    res_next               = '0;
                    res_next.kind          = sqb_pkg::KIND_BIND;
                    res_next.slot_number   = idx_reg;
                    res_next.bound_texture = table_reg[idx_reg[SIW-1:0]];
                    res_valid_next         = 1'b1;
                    idx_next               = idx_reg + 1'b1;
                end
            end
            S_DRAW:
            begin
                if (adv)
                begin
                    res_next                  = '0;
                    res_next.kind             = sqb_pkg::KIND_DRAW;
                    res_next.draw_index_count = quad_reg;
                    res_next.last             = !ret_reg;
                    res_valid_next            = 1'b1;
                    quad_next                 = '0;
                    count_next                = '0;
                    if (ret_reg)
                    begin
                        table_next[0] = tid_reg;
                        count_next    = sqb_pkg::SLOT_W'(1);
                        slot_next     = sqb_pkg::SLOT_W'(1);
                        state_next    = S_ISSUE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ISSUE:
            begin
                if (adv)
                begin
                    t1_next.valid = 1'b1;
                    step_next     = step_reg + 1'b1;
                    if (step_reg == '0 && sprite_reg)
                    begin
                        quad_next = (quad_sum > {1'b0, CAP}) ? CAP : quad_sum[14:0];
                    end
                    if (step_reg == 6'd63)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!t1_reg.valid && !t2_reg.valid)
                begin
                    if (!sprite_reg)
                    begin
                        level_next = level_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv && t2_reg.valid && t2_reg.step[1:0] == 2'd3)
        begin
            if (sprite_reg)
            begin
                if (t2_reg.step[3:2] != 2'd3)
                begin
                    row_next[t2_reg.step[3:2]] = mac_sum;
                end
                else
                begin
                    res_next             = '0;
                    res_next.kind        = sqb_pkg::KIND_VERTEX;
                    res_next.vert_x      = row_reg[0];
                    res_next.vert_y      = row_reg[1];
                    res_next.vert_z      = row_reg[2];
                    res_next.vert_w      = mac_sum;
                    res_next.corner      = t2_reg.step[5:4];
                    res_next.slot_number = slot_reg;
                    res_next.last        = (t2_reg.step[5:4] == 2'd3);
                    res_valid_next       = 1'b1;
                end
            end
            else
            begin
                mem_we    = 1'b1;
                mem_waddr = {LW'(level_reg + 1'b1), t2_reg.step[5:2]};
                mem_wdata = mac_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            level_reg     <= '0;
            staged_reg    <= '{default: '0};
            count_reg     <= '0;
            quad_reg      <= '0;
            t1_reg        <= '0;
            t2_reg        <= '0;
            res_valid_reg <= 1'b0;
            idx_reg       <= '0;
            step_reg      <= '0;
            sprite_reg    <= 1'b0;
            ret_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            staged_reg    <= staged_next;
            count_reg     <= count_next;
            quad_reg      <= quad_next;
            t1_reg        <= t1_next;
            t2_reg        <= t2_next;
            res_valid_reg <= res_valid_next;
            idx_reg       <= idx_next;
            step_reg      <= step_next;
            sprite_reg    <= sprite_next;
            ret_reg       <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        table_reg <= table_next;
        slot_reg  <= slot_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        pz_reg    <= pz_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        tid_reg   <= tid_next;
        row_reg   <= row_next;
        res_reg   <= res_next;
    end

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= TOP_LVL)
        else $error("stack level beyond top");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SLOTS)
        else $error("slot count beyond table");

    a_quad_cap: assert property (@(posedge clk) disable iff (!rst_n)
        quad_reg <= CAP)
        else $error("index count beyond cap");

    a_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_stall |-> (!t1_reg.valid && !t2_reg.valid))
        else $error("request taken while products in flight");

endmodule

>>> verif/sprite_quad_batcher_unit_tb.sv
// ----------------------------------------------------------------------------
// sprite_quad_batcher_unit_tb
// Drives matrix loads, pushes, pops, sprites and flushes into the batcher,
// first from a short table and then at random, under varying idle and stall
// patterns, and checks every result against a transaction-level batcher model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sprite_quad_batcher_unit_tb;

    localparam int DEPTH     = 16;
    localparam int SLOTS     = 15;
    localparam int INDEX_CAP = 24576;
    localparam int IDLE_MAX  = 20000;
    localparam int N_RANDOM  = 220;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    sqb_pkg::cmd_t cmd;
    logic res_valid;
    logic res_stall;
    sqb_pkg::res_t res;

    sprite_quad_batcher_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [31:0] xform_stack [DEPTH][16];
    logic [31:0] staged [16];
    logic [15:0] slot_ids [SLOTS];
    int          level;
    int          slots_used;
    int          quad_indices;

    sqb_pkg::res_t pending_results [$];
    int            mismatches;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            idle_cycles;

    function automatic logic [31:0] qmul(logic [31:0] a, logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        return p[47:16];
    endfunction

    function automatic sqb_pkg::res_t blank(sqb_pkg::kind_t k);
        sqb_pkg::res_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    task automatic queue_result(sqb_pkg::res_t r);
        pending_results = {pending_results, r};
    endtask

    task automatic emit_flush();
        sqb_pkg::res_t r;
        for (int i = 0; i < slots_used; i++)
        begin
            r = blank(sqb_pkg::KIND_BIND);
            r.slot_number = i[3:0];
            r.bound_texture = slot_ids[i];
            queue_result(r);
        end
        r = blank(sqb_pkg::KIND_DRAW);
        r.draw_index_count = quad_indices[14:0];
        queue_result(r);
        quad_indices = 0;
        slots_used = 0;
    endtask

    task automatic predict_batch(sqb_pkg::cmd_t c);
        int            n_prior;
        int            slot;
        bit            found;
        logic [31:0]   cx [4];
        logic [31:0]   cy [4];
        logic [31:0]   v [4];
        logic [31:0]   s;
        sqb_pkg::res_t r;
        n_prior = pending_results.size();
        case (c.opcode)
            sqb_pkg::OP_LOAD: staged[c.elem_index] = c.elem_value;
            sqb_pkg::OP_PUSH:
            begin
                if (level + 1 >= DEPTH)
                    queue_result(blank(sqb_pkg::KIND_ERROR));
                else
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        if (c.replace_top)
                            xform_stack[level + 1][i] = staged[i];
                        else
                        begin
                            s = '0;
                            for (int k = 0; k < 4; k++)
                                s += qmul(xform_stack[level][(i / 4) * 4 + k],
                                          staged[k * 4 + i % 4]);
                            xform_stack[level + 1][i] = s;
                        end
                    end
                    level++;
                end
            end
            sqb_pkg::OP_POP: if (level > 0) level--;
            sqb_pkg::OP_SPRITE:
            begin
                slot = 0;
                if (c.texture_id != 0)
                begin
                    found = 1'b0;
                    for (int i = 0; i < slots_used; i++)
                        if (!found && slot_ids[i] == c.texture_id)
                        begin
                            slot = i + 1;
                            found = 1'b1;
                        end
                    if (!found)
                    begin
                        if (slots_used >= SLOTS) emit_flush();
                        slot_ids[slots_used] = c.texture_id;
                        slots_used++;
                        slot = slots_used;
                    end
                end
                cx[0] = c.pos_x;            cy[0] = c.pos_y;
                cx[1] = c.pos_x;            cy[1] = c.pos_y + c.size_h;
                cx[2] = c.pos_x + c.size_w; cy[2] = c.pos_y + c.size_h;
                cx[3] = c.pos_x + c.size_w; cy[3] = c.pos_y;
                for (int k = 0; k < 4; k++)
                begin
                    r = blank(sqb_pkg::KIND_VERTEX);
                    for (int row = 0; row < 4; row++)
                        v[row] = qmul(xform_stack[level][row * 4], cx[k])
                               + qmul(xform_stack[level][row * 4 + 1], cy[k])
                               + qmul(xform_stack[level][row * 4 + 2], c.pos_z)
                               + qmul(xform_stack[level][row * 4 + 3], sqb_pkg::ONE_Q16);
                    r.vert_x = v[0];
                    r.vert_y = v[1];
                    r.vert_z = v[2];
                    r.vert_w = v[3];
                    r.corner = k[1:0];
                    r.slot_number = slot[3:0];
                    queue_result(r);
                end
                quad_indices = (quad_indices + 6 > INDEX_CAP) ? INDEX_CAP : quad_indices + 6;
            end
            sqb_pkg::OP_FLUSH: emit_flush();
            default: ;
        endcase
        if (pending_results.size() > n_prior)
            pending_results[pending_results.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk)
    begin
        sqb_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", res);
            end
            else
            begin
                want = pending_results.pop_front();
                if (res !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, res);
                end
            end
        end
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic sqb_pkg::cmd_t make_cmd(sqb_pkg::opcode_t op, logic [15:0] tex);
        sqb_pkg::cmd_t c;
        c = '0;
        c.opcode = op;
        c.texture_id = tex;
        c.pos_x = $urandom; c.pos_y = $urandom; c.pos_z = $urandom;
        c.size_w = $urandom; c.size_h = $urandom;
        c.elem_index = 4'($urandom); c.elem_value = $urandom;
        c.replace_top = 1'($urandom);
        return c;
    endfunction

    task automatic send_cmd(sqb_pkg::cmd_t c, bit has_expect, sqb_pkg::res_t expect_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= c;
        cmd_valid <= 1'b1;
        if (has_expect)
            queue_result(expect_res);
        else
            predict_batch(c);
        do @(posedge clk); while (cmd_stall);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    sqb_pkg::cmd_t directed_cmds [$];
    bit            directed_known [$];
    sqb_pkg::res_t directed_expect [$];

    task automatic add_row(sqb_pkg::cmd_t c, bit known, sqb_pkg::res_t r);
        directed_cmds = {directed_cmds, c};
        directed_known = {directed_known, known};
        directed_expect = {directed_expect, r};
    endtask

    initial
    begin
        sqb_pkg::cmd_t c;
        sqb_pkg::res_t r;
        int            op;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        level = 0;
        slots_used = 0;
        quad_indices = 0;
        for (int i = 0; i < DEPTH; i++)
            for (int j = 0; j < 16; j++)
                xform_stack[i][j] = (i == 0 && j % 5 == 0) ? sqb_pkg::ONE_Q16 : '0;
        for (int j = 0; j < 16; j++) staged[j] = '0;

        r = blank(sqb_pkg::KIND_DRAW);
        r.last = 1'b1;
        add_row(make_cmd(sqb_pkg::OP_FLUSH, 0), 1, r);
        c = make_cmd(sqb_pkg::OP_POP, 0);
        add_row(c, 0, r);
        c = make_cmd(sqb_pkg::OP_SPRITE, 16'h0);
        c.pos_x = 32'h7FFF_FFFF; c.size_w = 32'h7FFF_FFFF;
        c.pos_y = 32'h8000_0000; c.size_h = 32'h8000_0000;
        add_row(c, 0, r);
        c = make_cmd(sqb_pkg::OP_SPRITE, 16'hFFFF);
        add_row(c, 0, r);
        for (int k = 0; k < 16; k++)
        begin
            c = make_cmd(sqb_pkg::OP_LOAD, 0);
            c.elem_index = 4'(k);
            c.elem_value = (k == 15) ? 32'h8000_0000 : (k % 5 == 0 ? 32'h7FFF_FFFF : $urandom);
            if (k % 5 == 0 || k == 15) add_row(c, 0, r);
        end
        c = make_cmd(sqb_pkg::OP_PUSH, 0); c.replace_top = 1'b0; add_row(c, 0, r);
        c = make_cmd(sqb_pkg::OP_SPRITE, 16'd1); add_row(c, 0, r);
        c = make_cmd(sqb_pkg::OP_PUSH, 0); c.replace_top = 1'b1; add_row(c, 0, r);
        c = make_cmd(sqb_pkg::OP_SPRITE, 16'd1); add_row(c, 0, r);
        add_row(make_cmd(sqb_pkg::opcode_t'(3'd5), 0), 0, r);
        add_row(make_cmd(sqb_pkg::opcode_t'(3'd7), 0), 0, r);
        add_row(make_cmd(sqb_pkg::OP_FLUSH, 0), 0, r);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cmds[i])
            send_cmd(directed_cmds[i], directed_known[i], directed_expect[i]);
        drain();

        r = blank(sqb_pkg::KIND_ERROR);
        r.last = 1'b1;
        for (int i = 0; i < 18; i++)
        begin
            c = make_cmd(sqb_pkg::OP_PUSH, 0);
            send_cmd(c, 0, r);
        end
        for (int i = 0; i < 17; i++) send_cmd(make_cmd(sqb_pkg::OP_POP, 0), 0, r);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 28 : 46) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 28 : 46) : 0;
            for (int i = 0; i < N_RANDOM / 4; i++)
            begin
                op = $urandom_range(99);
                if (op < 45)
                    c = make_cmd(sqb_pkg::OP_SPRITE, ($urandom_range(3) == 0) ? 16'h0 :
                                 (($urandom_range(4) == 0) ? 16'($urandom) :
                                  16'($urandom_range(20))));
                else if (op < 65)
                    c = make_cmd(sqb_pkg::OP_LOAD, 0);
                else if (op < 75)
                    c = make_cmd(sqb_pkg::OP_PUSH, 0);
                else if (op < 85)
                    c = make_cmd(sqb_pkg::OP_POP, 0);
                else if (op < 95)
                    c = make_cmd(sqb_pkg::OP_FLUSH, 0);
                else
                    c = make_cmd(sqb_pkg::opcode_t'(3'($urandom_range(7))), 0);
                if (c.opcode == sqb_pkg::OP_LOAD && $urandom_range(1))
                    c.elem_value = $urandom_range(32'h0002_0000);
                send_cmd(c, 0, r);
            end
            drain();
        end
        recv_stall_pct = 0;
        drain();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sprite_quad_batcher_unit.f
sv/sqb_pkg.sv
sv/sqb_stack_mem.sv
sv/sqb_mac.sv
sv/sprite_quad_batcher_unit.sv
verif/sprite_quad_batcher_unit_tb.sv
